// File: hw/rtl/ssq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssq_pkg
// Types, codes and defaults shared by the stable sorted priority queue.
// ----------------------------------------------------------------------------
package ssq_pkg;

   localparam int CAPACITY_DEFAULT = 16;
   localparam int COUNT_OUT_WIDTH  = 5;

   localparam logic       OP_INSERT = 1'b0;
   localparam logic       OP_POP    = 1'b1;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [15:0] key;
      logic [7:0]  pickup;
      logic [7:0]  dropoff;
      logic [1:0]  kind;
      logic [15:0] time_limit;
   } entry_type;

   typedef struct packed {
      logic        op;
      logic [15:0] key;
      logic [7:0]  pickup;
      logic [7:0]  dropoff;
      logic [1:0]  kind;
      logic [15:0] time_limit;
   } req_type;

   typedef struct packed {
      logic [15:0]                out_key;
      logic [7:0]                 out_pickup;
      logic [7:0]                 out_dropoff;
      logic [1:0]                 out_kind;
      logic [15:0]                out_time_limit;
      logic [1:0]                 status;
      logic [COUNT_OUT_WIDTH-1:0] count;
      logic                       is_empty;
      logic                       is_full;
   } rsp_type;

   // Broadcast to every cell of the row.
   typedef struct packed {
      logic      insert;
      logic      pop;
      entry_type entry;
   } ctl_type;

endpackage
`default_nettype wire

// File: hw/rtl/stable_sorted_priority_queue_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue_top
// Bounded priority queue kept sorted by key in a row of compare-and-shift
// cells.
// ----------------------------------------------------------------------------
// One transaction is taken per clock cycle while req_stall is low, and its
// result appears on the rsp channel in the cycle after acceptance; every
// cell compares against the incoming key at once and the whole row shifts
// in that same cycle. Inserts go after all entries of equal key, pops
// return the head. An insert into a full queue is dropped with status
// FULL, a pop of an empty queue returns status EMPTY. The count field
// carries the low five bits of the fill level.
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue_top
   import ssq_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_stall,
   input  wire req_type req_data,
   output      logic    rsp_valid,
   input  wire logic    rsp_stall,
   output      rsp_type rsp_data
);

   localparam int CW = $clog2(CAPACITY + 1);

   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   rsp_type       rsp_ff;
   rsp_type       rsp_in;

   logic          accept;
   logic          is_full_now;
   logic          is_empty_now;
   ctl_type       ctl;

   entry_type     cell_entry [CAPACITY];
   logic          cell_gt    [CAPACITY];

   // Accept while the output slot is free or drains this cycle.
   assign req_stall    = rsp_valid_ff && rsp_stall;
   assign accept       = req_valid && !req_stall;
   assign is_full_now  = (count_ff == CW'(CAPACITY));
   assign is_empty_now = (count_ff == '0);

   always_comb begin
      ctl.entry.key        = req_data.key;
      ctl.entry.pickup     = req_data.pickup;
      ctl.entry.dropoff    = req_data.dropoff;
      ctl.entry.kind       = req_data.kind;
      ctl.entry.time_limit = req_data.time_limit;
      ctl.insert = accept && (req_data.op == OP_INSERT) && !is_full_now;
      ctl.pop    = accept && (req_data.op == OP_POP) && !is_empty_now;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic      occupied;
      logic      left_gt;
      entry_type left_entry;
      entry_type right_entry;

      assign occupied = (CW'(i) < count_ff);

      if (i == 0) begin : g_head
         assign left_gt    = 1'b0;
         assign left_entry = ctl.entry;
      end else begin : g_body
         assign left_gt    = cell_gt[i-1];
         assign left_entry = cell_entry[i-1];
      end

      // The tail slot falls out of range on a pop; its contents do not matter.
      if (i == CAPACITY - 1) begin : g_tail
         assign right_entry = cell_entry[i];
      end else begin : g_inner
         assign right_entry = cell_entry[i+1];
      end

      ssq_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .occupied    (occupied),
         .left_gt     (left_gt),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .gt          (cell_gt[i]),
         .entry       (cell_entry[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.insert) begin
         count_in = count_ff + CW'(1);
      end else if (ctl.pop) begin
         count_in = count_ff - CW'(1);
      end

      rsp_in                = '0;
      rsp_in.status         = STATUS_DONE;
      if (req_data.op == OP_INSERT) begin
         if (is_full_now) begin
            rsp_in.status = STATUS_FULL;
         end
      end else begin
         if (is_empty_now) begin
            rsp_in.status = STATUS_EMPTY;
         end else begin
            rsp_in.out_key        = cell_entry[0].key;
            rsp_in.out_pickup     = cell_entry[0].pickup;
            rsp_in.out_dropoff    = cell_entry[0].dropoff;
            rsp_in.out_kind       = cell_entry[0].kind;
            rsp_in.out_time_limit = cell_entry[0].time_limit;
         end
      end
      rsp_in.count    = COUNT_OUT_WIDTH'(count_in);
      rsp_in.is_empty = (count_in == '0);
      rsp_in.is_full  = (count_in == CW'(CAPACITY));

      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// File: hw/rtl/ssq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssq_cell
// One slot of the sorted row: compares its key with the broadcast entry,
// then holds, takes the new entry, takes its left neighbour or its right one.
// ----------------------------------------------------------------------------
module ssq_cell
   import ssq_pkg::*;
(
   input  wire logic      clock,
   input  wire ctl_type   ctl,
   input  wire logic      occupied,
   input  wire logic      left_gt,
   input  wire entry_type left_entry,
   input  wire entry_type right_entry,
   output      logic      gt,
   output      entry_type entry
);

   entry_type entry_ff;
   entry_type entry_in;

   // An empty slot counts as greater, so the new entry lands at the tail.
   assign gt    = !occupied || (entry_ff.key > ctl.entry.key);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.insert) begin
         if (left_gt) begin
            entry_in = left_entry;
         end else if (gt) begin
            entry_in = ctl.entry;
         end
      end else if (ctl.pop) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule
`default_nettype wire
